FILE: rtl/core/indexed_list_engine_core_macros.svh
// Assertion macros shared by the indexed list engine RTL.
// Expects clk and rst in scope at the point of use.
`ifndef INDEXED_LIST_ENGINE_CORE_MACROS_SVH
`define INDEXED_LIST_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ILE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define ILE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ile_pkg.sv
// Shared constants, types and codes of the indexed list engine.
// No dependencies.
package ile_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int MODE_W   = 3;
  localparam int POS_W    = 7;
  localparam int FPOS_W   = 6;
  localparam int ECNT_W   = 7;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CMP_W-1:0]  cmp_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 3'd0,
    MODE_REMOVE = 3'd1,
    MODE_READ   = 3'd2,
    MODE_WRITE  = 3'd3,
    MODE_SEARCH = 3'd4,
    MODE_CLEAR  = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

endpackage

FILE: rtl/core/ile_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependencies.
module ile_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/indexed_list_engine_core.sv
// Indexed list engine: bounded ordered list of signed 32-bit values in one RAM.
// Depends on ile_pkg, ile_ram and indexed_list_engine_core_macros.svh.
//
// Usage: a request (mode, position, item_value) is taken at a clock edge where
// start is high and busy is low. Exactly one result follows: status, read_data,
// found, found_position and element_count are valid for the single cycle in
// which done is high. The receiver cannot stall; the result outputs keep their values until the next done.
// A new request may be issued in the same cycle that done is high.
// Errors, overwrite, clear, unused modes, insert at the end and remove of the
// last entry finish in S_IDLE; a read goes on to S_READ. A search steps up
// from entry 0 in S_SEARCH until a hit or the last entry. An insert shifts
// entries in S_SHIFT from the end down to the position, then writes the new
// value in S_PUT; a remove shifts the entries above the position down by one.
// The length of a request is set by the single RAM read and write port:
// shifts and scans move one entry per cycle through one shared address
// stepper. The longest requests are an insert at 0 and a full-list search.
// Reset (synchronous, rst high) empties the list and drops any request in
// flight; RAM contents are left as they are and are only read below count.
`include "indexed_list_engine_core_macros.svh"

module indexed_list_engine_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [ile_pkg::MODE_W-1:0]       mode,
  input  logic [ile_pkg::POS_W-1:0]        position,
  input  logic signed [ile_pkg::DATA_W-1:0] item_value,
  output logic                             done,
  output ile_pkg::status_t                 status,
  output logic signed [ile_pkg::DATA_W-1:0] read_data,
  output logic                             found,
  output logic [ile_pkg::FPOS_W-1:0]       found_position,
  output logic [ile_pkg::ECNT_W-1:0]       element_count
);

  import ile_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_SEARCH = 5'b00100,
    S_SHIFT  = 5'b01000,
    S_PUT    = 5'b10000
  } state_t;

  state_t state, state_next;
  cnt_t   count, count_next;
  logic [MODE_W-1:0] op, op_next;
  addr_t  pos_q, pos_next;
  logic [DATA_W-1:0] val_q, val_next;
  addr_t  src, src_next;
  addr_t  dst, dst_next;

  logic              ram_we;
  addr_t             ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, rdata;

  logic              fin;
  status_t           res_status;
  logic [DATA_W-1:0] res_rdata;
  logic              res_found;
  addr_t             res_fpos;

  cmp_t  pos_c, cnt_c, cnt_last;
  addr_t pos_a, src_adj;

  assign pos_c    = cmp_t'(position);
  assign pos_a    = addr_t'(position);
  assign cnt_c    = cmp_t'(count);
  assign cnt_last = cnt_c - cmp_t'(1);

  // shared address stepper: down for insert shifts, up for remove and search
  assign src_adj = src + ((op == MODE_INSERT) ? '1 : addr_t'(1));

  assign busy = (state != S_IDLE);

  ile_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    count_next = count;
    op_next    = op;
    pos_next   = pos_q;
    val_next   = val_q;
    src_next   = src;
    dst_next   = dst;
    ram_we     = 1'b0;
    ram_waddr  = dst;
    ram_wdata  = rdata;
    ram_raddr  = src;
    fin        = 1'b0;
    res_status = ST_OK;
    res_rdata  = '0;
    res_found  = 1'b0;
    res_fpos   = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          op_next  = mode;
          pos_next = pos_a;
          val_next = item_value;
          case (mode)
            MODE_INSERT: begin
              if (pos_c > cnt_c) begin
                res_status = ST_BOUNDS;
                fin        = 1'b1;
              end else if (count == cnt_t'(CAPACITY)) begin
                res_status = ST_FULL;
                fin        = 1'b1;
              end else if (pos_c == cnt_c) begin
                ram_we     = 1'b1;
                ram_waddr  = pos_a;
                ram_wdata  = item_value;
                count_next = count + cnt_t'(1);
                fin        = 1'b1;
              end else begin
                ram_raddr  = addr_t'(cnt_last);
                src_next   = addr_t'(cnt_last);
                dst_next   = addr_t'(count);
                state_next = S_SHIFT;
              end
            end
            MODE_REMOVE: begin
              if (pos_c >= cnt_c) begin
                res_status = ST_BOUNDS;
                fin        = 1'b1;
              end else if (pos_c == cnt_last) begin
                count_next = count - cnt_t'(1);
                fin        = 1'b1;
              end else begin
                ram_raddr  = pos_a + addr_t'(1);
                src_next   = pos_a + addr_t'(1);
                dst_next   = pos_a;
                state_next = S_SHIFT;
              end
            end
            MODE_READ: begin
              if (pos_c >= cnt_c) begin
                res_status = ST_BOUNDS;
                fin        = 1'b1;
              end else begin
                ram_raddr  = pos_a;
                state_next = S_READ;
              end
            end
            MODE_WRITE: begin
              if (pos_c >= cnt_c) begin
                res_status = ST_BOUNDS;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = pos_a;
                ram_wdata = item_value;
              end
              fin = 1'b1;
            end
            MODE_SEARCH: begin
              if (count == '0) begin
                fin = 1'b1;
              end else begin
                ram_raddr  = '0;
                src_next   = '0;
                state_next = S_SEARCH;
              end
            end
            MODE_CLEAR: begin
              count_next = '0;
              fin        = 1'b1;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      S_READ: begin
        res_rdata  = rdata;
        fin        = 1'b1;
        state_next = S_IDLE;
      end

      S_SEARCH: begin
        // rdata holds the entry at src
        if (rdata == val_q) begin
          res_found  = 1'b1;
          res_fpos   = src;
          fin        = 1'b1;
          state_next = S_IDLE;
        end else if (cmp_t'(src) == cnt_last) begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end else begin
          ram_raddr = src_adj;
          src_next  = src_adj;
        end
      end

      S_SHIFT: begin
        // move the entry read last cycle one place toward dst
        ram_we = 1'b1;
        if (op == MODE_INSERT) begin
          if (src == pos_q) begin
            state_next = S_PUT;
          end else begin
            ram_raddr = src_adj;
            src_next  = src_adj;
            dst_next  = src;
          end
        end else begin
          if (cmp_t'(src) == cnt_last) begin
            count_next = count - cnt_t'(1);
            fin        = 1'b1;
            state_next = S_IDLE;
          end else begin
            ram_raddr = src_adj;
            src_next  = src_adj;
            dst_next  = src;
          end
        end
      end

      S_PUT: begin
        ram_we     = 1'b1;
        ram_waddr  = pos_q;
        ram_wdata  = val_q;
        count_next = count + cnt_t'(1);
        fin        = 1'b1;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    op    <= op_next;
    pos_q <= pos_next;
    val_q <= val_next;
    src   <= src_next;
    dst   <= dst_next;
    if (fin) begin
      status         <= res_status;
      read_data      <= res_rdata;
      found          <= res_found;
      found_position <= FPOS_W'(res_fpos);
      element_count  <= ECNT_W'(count_next);
    end
  end

  `ILE_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while a request is in flight")
  `ILE_ASSERT_NEXT(a_req_answered, start && !busy, done || busy, "accepted request dropped")
  `ILE_ASSERT_NOW(a_full_count, done && status == ST_FULL, count == cnt_t'(CAPACITY), "full status with room left")
  `ILE_ASSERT_NOW(a_err_clean, done && status != ST_OK, read_data == '0 && !found, "error result carries data")
  `ILE_ASSERT_NOW(a_shift_writes, state == S_SHIFT || state == S_PUT, ram_we, "shift cycle without a RAM write")

endmodule
